// ===== src/scm_pkg.sv =====
package scm_pkg;

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] key;
        logic [31:0] remove_count;
    } t_in_item;

    typedef struct packed {
        logic        status;
        logic [31:0] count_result;
        logic [6:0]  unique_entries;
        logic [31:0] total_copies;
    } t_out_item;

    // One decoded item as it waits between the front and the back.
    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] key;
        logic [31:0] remove_count;
    } t_job;

endpackage

// ===== src/scm_front.sv =====
module scm_front
    import scm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     push,
    output logic     full,
    input  t_in_item i_item,
    output t_job     o_job,
    output logic     o_job_valid,
    input  logic     i_job_take
);

    t_job       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_job       n_job;
    logic       w_push;
    logic       w_take;

    always_comb begin
        n_job.key          = i_item.key;
        n_job.remove_count = i_item.remove_count;
        case (i_item.cmd)
            CMD_INSERT: n_job.cmd = CMD_INSERT;
            CMD_FIND:   n_job.cmd = CMD_FIND;
            CMD_DELETE: n_job.cmd = CMD_DELETE;
            default:    n_job.cmd = CMD_NONE;
        endcase
    end

    assign full        = (r_cnt == 2'd2);
    assign w_push      = push && !full;
    assign o_job_valid = (r_cnt != 2'd0);
    assign w_take      = i_job_take && o_job_valid;
    assign o_job       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= n_job;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (w_take) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_take);
        end
    end

endmodule

// ===== src/scm_back.sv =====
module scm_back
    import scm_pkg::*;
#(
    parameter int ENTRIES   = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  logic      i_job_valid,
    output logic      o_job_take,
    input  logic      i_pop,
    output t_out_item o_out,
    output logic      o_out_valid
);

    localparam int NW = $clog2(ENTRIES + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                 r_state;
    logic [KEY_WIDTH-1:0]   r_keys [ENTRIES];
    logic [31:0]            r_cnts [ENTRIES];
    logic [NW-1:0]          r_num;
    logic [31:0]            r_copies;
    logic [ENTRIES-1:0]     r_lt;
    logic [ENTRIES-1:0]     r_eq;
    logic                   r_hit;
    logic [31:0]            r_hcnt;
    t_cmd                   r_cmd;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [31:0]            r_rc;
    t_out_item              r_out;
    logic                   r_out_valid;

    logic [63:0]            w_key_wide;
    logic [KEY_WIDTH-1:0]   w_key;
    logic [ENTRIES-1:0]     w_lt;
    logic [ENTRIES-1:0]     w_eq;
    logic [31:0]            w_hcnt;
    logic                   w_full;
    logic                   w_del_all;
    logic                   w_ins_new;
    logic [31:0]            w_copies_inc;
    logic [31:0]            n_res;
    logic                   n_status;
    logic [NW-1:0]          n_num;
    logic [31:0]            n_copies;

    assign w_key_wide = 64'(i_job.key);
    assign w_key      = w_key_wide[KEY_WIDTH-1:0];

    // Every cell compares against the key at once; the table is sorted, so the
    // below-key flags form a run from cell 0 and at most one cell matches.
    always_comb begin
        w_hcnt = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            w_lt[i] = (NW'(i) < r_num) && (r_keys[i] < w_key);
            w_eq[i] = (NW'(i) < r_num) && (r_keys[i] == w_key);
            w_hcnt  = w_hcnt | (w_eq[i] ? r_cnts[i] : 32'd0);
        end
    end

    assign o_job_take = (r_state == S_IDLE) && i_job_valid && (!r_out_valid || i_pop);

    assign w_full       = (r_num == NW'(ENTRIES));
    assign w_del_all    = (r_rc == 32'd0) || (r_rc >= r_hcnt);
    assign w_ins_new    = (r_cmd == CMD_INSERT) && !r_hit && !w_full;
    assign w_copies_inc = (r_copies == CNT_MAX) ? r_copies : r_copies + 32'd1;

    always_comb begin
        n_res    = '0;
        n_status = 1'b0;
        n_num    = r_num;
        n_copies = r_copies;
        case (r_cmd)
            CMD_INSERT: begin
                if (r_hit) begin
                    if (r_hcnt != CNT_MAX) begin
                        n_res    = r_hcnt + 32'd1;
                        n_copies = w_copies_inc;
                    end else begin
                        n_res = r_hcnt;
                    end
                end else if (w_full) begin
                    n_status = 1'b1;
                end else begin
                    n_res    = 32'd1;
                    n_num    = r_num + NW'(1);
                    n_copies = w_copies_inc;
                end
            end
            CMD_FIND: begin
                n_res = r_hit ? r_hcnt : 32'd0;
            end
            CMD_DELETE: begin
                if (r_hit) begin
                    if (w_del_all) begin
                        n_res = r_hcnt;
                        n_num = r_num - NW'(1);
                    end else begin
                        n_res = r_rc;
                    end
                    n_copies = (r_copies > n_res) ? r_copies - n_res : 32'd0;
                end
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == ENTRIES - 1) ? g : g + 1;
        logic w_at_pos;

        // The insert position is the first cell not below the key.
        assign w_at_pos = !r_lt[g] && ((g == 0) || r_lt[PREV]);

        always_ff @(posedge i_clk) begin
            if (r_state == S_EXEC) begin
                if (r_cmd == CMD_INSERT && r_hit && r_eq[g] && r_hcnt != CNT_MAX) begin
                    r_cnts[g] <= r_cnts[g] + 32'd1;
                end else if (w_ins_new && !r_lt[g]) begin
                    if (w_at_pos) begin
                        r_keys[g] <= r_key;
                        r_cnts[g] <= 32'd1;
                    end else begin
                        r_keys[g] <= r_keys[PREV];
                        r_cnts[g] <= r_cnts[PREV];
                    end
                end else if (r_cmd == CMD_DELETE && r_hit) begin
                    if (w_del_all) begin
                        if (!r_lt[g]) begin
                            r_keys[g] <= r_keys[NEXT];
                            r_cnts[g] <= r_cnts[NEXT];
                        end
                    end else if (r_eq[g]) begin
                        r_cnts[g] <= r_cnts[g] - r_rc;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_lt   <= w_lt;
            r_eq   <= w_eq;
            r_hit  <= |w_eq;
            r_hcnt <= w_hcnt;
            r_cmd  <= i_job.cmd;
            r_key  <= w_key;
            r_rc   <= i_job.remove_count;
        end
        if (r_state == S_EXEC) begin
            r_out.status         <= n_status;
            r_out.count_result   <= n_res;
            r_out.unique_entries <= 7'(n_num);
            r_out.total_copies   <= n_copies;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num       <= '0;
            r_copies    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_pop) begin
                        r_out_valid <= 1'b0;
                    end
                    if (o_job_take) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_num       <= n_num;
                    r_copies    <= n_copies;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

endmodule

// ===== src/sorted_counted_multiset.sv =====
// Sorted multiset of up to ENTRIES distinct keys, each with a copy count. Items
// enter through a two-deep queue; the back end handles each item in steps (it first
// compares the key against every table cell at once, then shifts or updates the
// cells), and the result then sits in an output register until popped. The back
// end takes no new item until it has finished the last one and the output register
// is empty or being popped. Keys are compared unsigned on their low KEY_WIDTH bits.
// A new key offered to a full table is dropped and reported with status 1.
module sorted_counted_multiset
    import scm_pkg::*;
#(
    parameter int ENTRIES   = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_item
);

    t_job w_job;
    logic w_job_valid;
    logic w_job_take;
    logic w_out_valid;

    scm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_job       (w_job),
        .o_job_valid (w_job_valid),
        .i_job_take  (w_job_take)
    );

    scm_back #(
        .ENTRIES   (ENTRIES),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job),
        .i_job_valid (w_job_valid),
        .o_job_take  (w_job_take),
        .i_pop       (pop),
        .o_out       (o_item),
        .o_out_valid (w_out_valid)
    );

    assign empty = !w_out_valid;

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    import scm_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int CYCLE_LIMIT = 2000000;

    logic      i_clk;
    logic      i_rst_n;
    logic      push;
    logic      full;
    t_in_item  i_item;
    logic      empty;
    logic      pop;
    t_out_item o_item;

    sorted_counted_multiset u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_item  (i_item),
        .empty   (empty),
        .pop     (pop),
        .o_item  (o_item)
    );

    // Shadow copy of the table.
    logic [31:0] shadow_keys [TABLE_DEPTH];
    logic [31:0] shadow_counts [TABLE_DEPTH];
    int          shadow_distinct;
    logic [31:0] shadow_copies;

    t_out_item pending_results [$];
    int        mismatch_count;
    int        result_count;
    int        cycle_count;
    int        send_idle_pct;
    int        pop_stall_pct;
    int        items_sent;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_out_item predict_multiset(t_in_item it);
        t_out_item   r;
        int          pos;
        bit          hit;
        logic [31:0] c;
        r = '0;
        pos = 0;
        while (pos < shadow_distinct && shadow_keys[pos] < it.key) pos++;
        hit = (pos < shadow_distinct) && (shadow_keys[pos] == it.key);
        case (it.cmd)
            CMD_INSERT: begin
                if (hit) begin
                    if (shadow_counts[pos] != CNT_MAX) begin
                        shadow_counts[pos]++;
                        if (shadow_copies != CNT_MAX) shadow_copies++;
                    end
                    r.count_result = shadow_counts[pos];
                end else if (shadow_distinct >= TABLE_DEPTH) begin
                    r.status = 1'b1;
                end else begin
                    for (int i = shadow_distinct; i > pos; i--) begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_counts[i] = shadow_counts[i-1];
                    end
                    shadow_keys[pos] = it.key;
                    shadow_counts[pos] = 32'd1;
                    shadow_distinct++;
                    if (shadow_copies != CNT_MAX) shadow_copies++;
                    r.count_result = 32'd1;
                end
            end
            CMD_FIND: begin
                if (hit) r.count_result = shadow_counts[pos];
            end
            CMD_DELETE: begin
                if (hit) begin
                    c = shadow_counts[pos];
                    if (it.remove_count == 0 || it.remove_count >= c) begin
                        r.count_result = c;
                        for (int i = pos; i + 1 < shadow_distinct; i++) begin
                            shadow_keys[i] = shadow_keys[i+1];
                            shadow_counts[i] = shadow_counts[i+1];
                        end
                        shadow_distinct--;
                    end else begin
                        r.count_result = it.remove_count;
                        shadow_counts[pos] = c - it.remove_count;
                    end
                    shadow_copies = (shadow_copies > r.count_result) ?
                                    shadow_copies - r.count_result : 32'd0;
                end
            end
            default: ;
        endcase
        r.unique_entries = shadow_distinct[6:0];
        r.total_copies = shadow_copies;
        return r;
    endfunction

    // Called at a falling edge; push stays high after the item is taken so that
    // an item that follows at once needs no second assignment in the same step.
    task automatic send_item(input t_cmd cmd, input logic [31:0] key,
                             input logic [31:0] remove_count);
        t_in_item it;
        it.cmd = cmd;
        it.key = key;
        it.remove_count = remove_count;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        pending_results.push_back(predict_multiset(it));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // Result checker, sampling at the rising edge.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            result_count++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", o_item);
            end else begin
                want = pending_results.pop_front();
                if (o_item.status !== want.status ||
                    o_item.count_result !== want.count_result ||
                    o_item.unique_entries !== want.unique_entries ||
                    o_item.total_copies !== want.total_copies) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: exp st=%0d cnt=%0d uniq=%0d tot=%0d,",
                                 want.status, want.count_result, want.unique_entries,
                                 want.total_copies);
                        $display("          got st=%0d cnt=%0d uniq=%0d tot=%0d",
                                 o_item.status, o_item.count_result,
                                 o_item.unique_entries, o_item.total_copies);
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[sorted_counted_multiset] ERROR");
            $finish;
        end
    end

    task automatic test_directed();
        send_item(CMD_FIND, 32'd5, 32'd0);
        send_item(CMD_DELETE, 32'd5, 32'd0);
        send_item(CMD_INSERT, 32'hFFFF_FFFF, 32'd0);
        send_item(CMD_INSERT, 32'd0, 32'hFFFF_FFFF);
        send_item(CMD_INSERT, 32'd0, 32'd0);
        send_item(CMD_INSERT, 32'h8000_0000, 32'd0);
        send_item(CMD_FIND, 32'd0, 32'd0);
        send_item(CMD_FIND, 32'hFFFF_FFFF, 32'd0);
        send_item(CMD_NONE, 32'd0, 32'hFFFF_FFFF);
        send_item(CMD_DELETE, 32'd0, 32'd1);
        send_item(CMD_DELETE, 32'd0, 32'hFFFF_FFFF);
        send_item(CMD_DELETE, 32'h8000_0000, 32'd0);
        send_item(CMD_DELETE, 32'hFFFF_FFFF, 32'd7);
        send_item(CMD_FIND, 32'h8000_0000, 32'd0);
        drain_results();
    endtask

    // Fills the table, offers new keys to it while full, then deletes every key it put in.
    task automatic test_full_table();
        logic [31:0] fill_keys [TABLE_DEPTH];
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            fill_keys[i] = $urandom_range(TABLE_DEPTH - 1) * 32'd3 + i * 32'd200;
            send_item(CMD_INSERT, fill_keys[i], 0);
        end
        for (int i = 0; i < 5; i++)
            send_item(CMD_INSERT, 32'd100000 + i, 0);
        send_item(CMD_INSERT, 32'd200, 0);
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(CMD_DELETE, fill_keys[i], $urandom_range(1));
        drain_results();
    endtask

    // Random traffic on a small key pool so hits are common.
    task automatic test_random(input int n);
        logic [31:0] key;
        logic [31:0] amount;
        t_cmd        cmd;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4: cmd = CMD_INSERT;
                5, 6:          cmd = CMD_FIND;
                7, 8:          cmd = CMD_DELETE;
                default:       cmd = CMD_NONE;
            endcase
            if ($urandom_range(9) == 0) key = $urandom();
            else key = {{24{1'($urandom_range(1))}}, 8'($urandom_range(79))};
            case ($urandom_range(3))
                0: amount = 32'd0;
                1: amount = $urandom();
                default: amount = $urandom_range(3);
            endcase
            send_item(cmd, key, amount);
        end
        drain_results();
    endtask

    initial begin
        push = 1'b0;
        i_item = '0;
        i_rst_n = 1'b0;
        mismatch_count = 0;
        result_count = 0;
        cycle_count = 0;
        items_sent = 0;
        shadow_distinct = 0;
        shadow_copies = '0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_full_table();
        test_random(400);
        send_idle_pct = 70;
        test_random(400);
        send_idle_pct = 0;
        pop_stall_pct = 70;
        test_random(400);
        send_idle_pct = 10;
        pop_stall_pct = 10;
        test_random(350);
        pop_stall_pct = 0;
        drain_results();
        $display("Sent %0d items (insert, find, delete, unused command, full table),",
                 items_sent);
        $display("checked %0d results under four idle and stall mixes.", result_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("[sorted_counted_multiset] OK");
        end else begin
            $display("[sorted_counted_multiset] ERROR");
        end
        $finish;
    end
endmodule
